### src/osv_pkg.sv
// ----------------------------------------------------------------------------
// Octant shadowcast visibility package
// Shared types for the shadow list slots and the control strobes that run
// along the chain.
// ----------------------------------------------------------------------------
`default_nettype none
package osv_pkg;

    localparam int FracW = 5;
    localparam int ProdW = 2 * FracW;

    typedef struct packed {
        logic [FracW-1:0] sn;
        logic [FracW-1:0] sd;
        logic [FracW-1:0] en;
        logic [FracW-1:0] ed;
    } t_shade;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_JOIN   = 3'd1,
        OP_START  = 3'd2,
        OP_END    = 3'd3,
        OP_INSERT = 3'd4
    } t_op;

    // Broadcast to every slot for one request.
    typedef struct packed {
        logic   clear;
        logic   check;
        t_op    op;
        t_shade shade;
    } t_bcast;

    // State that each slot hands to both neighbors.
    typedef struct packed {
        logic   f;
        logic   valid;
        t_shade shade;
    } t_link;

    function automatic logic frac_le(input logic [FracW-1:0] a, input logic [FracW-1:0] b,
                                     input logic [FracW-1:0] c, input logic [FracW-1:0] d);
        logic [ProdW-1:0] p;
        logic [ProdW-1:0] q;
        p = ProdW'(a) * ProdW'(d);
        q = ProdW'(c) * ProdW'(b);
        return p <= q;
    endfunction

    function automatic logic frac_lt(input logic [FracW-1:0] a, input logic [FracW-1:0] b,
                                     input logic [FracW-1:0] c, input logic [FracW-1:0] d);
        logic [ProdW-1:0] p;
        logic [ProdW-1:0] q;
        p = ProdW'(a) * ProdW'(d);
        q = ProdW'(c) * ProdW'(b);
        return p < q;
    endfunction

endpackage
`default_nettype wire

### src/osv_cell.sv
// ----------------------------------------------------------------------------
// Shadow list slot
// Holds one shadow interval and a valid flag. Registers its compare of the
// broadcast interval and updates itself in a later cycle from its own flags and
// those of its neighbors, which together place the insertion point.
// ----------------------------------------------------------------------------
`default_nettype none
module osv_cell import osv_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_bcast i_bc,
    input  wire t_link  i_left,
    input  wire t_link  i_right,
    output t_link       o_link,
    output logic        o_cover,
    output logic        o_prev_hit,
    output logic        o_next_hit
);

    logic   r_valid;
    t_shade r_shade;
    logic   r_f;
    logic   r_p;
    logic   r_q;
    logic   r_cov;
    logic   n_valid;
    t_shade n_shade;
    logic   at_i;
    logic   is_prev;
    t_shade w;

    assign w = i_bc.shade;

    // The slot is the insertion point when the new start goes at or before it
    // and after its left neighbor; the slot just left of that is prev.
    assign at_i    = r_f && !i_left.f;
    assign is_prev = !r_f && i_right.f;

    always_comb begin
        n_valid = r_valid;
        n_shade = r_shade;
        case (i_bc.op)
            OP_JOIN: begin
                if (is_prev) begin
                    n_shade.en = i_right.shade.en;
                    n_shade.ed = i_right.shade.ed;
                end else if (r_f) begin
                    n_shade = i_right.shade;
                    n_valid = i_right.valid;
                end
            end
            OP_START: begin
                if (at_i) begin
                    n_shade.sn = w.sn;
                    n_shade.sd = w.sd;
                end
            end
            OP_END: begin
                if (is_prev) begin
                    n_shade.en = w.en;
                    n_shade.ed = w.ed;
                end
            end
            OP_INSERT: begin
                if (at_i) begin
                    n_shade = w;
                    n_valid = 1'b1;
                end else if (r_f) begin
                    n_shade = i_left.shade;
                    n_valid = i_left.valid;
                end
            end
            default: begin
            end
        endcase
        if (i_bc.clear) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_shade <= '0;
            r_f     <= 1'b0;
            r_p     <= 1'b0;
            r_q     <= 1'b0;
            r_cov   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_shade <= n_shade;
            if (i_bc.check) begin
                r_f   <= !r_valid || frac_le(w.sn, w.sd, r_shade.sn, r_shade.sd);
                r_p   <= frac_lt(w.sn, w.sd, r_shade.en, r_shade.ed);
                r_q   <= frac_lt(r_shade.sn, r_shade.sd, w.en, w.ed);
                r_cov <= r_valid
                    && frac_le(r_shade.sn, r_shade.sd, w.sn, w.sd)
                    && frac_le(w.en, w.ed, r_shade.en, r_shade.ed);
            end
        end
    end

    assign o_link     = '{f: r_f, valid: r_valid, shade: r_shade};
    assign o_cover    = r_cov;
    assign o_prev_hit = is_prev && r_p;
    assign o_next_hit = at_i && r_valid && r_q;

endmodule
`default_nettype wire

### src/octant_shadowcast_visibility.sv
// ----------------------------------------------------------------------------
// Octant shadowcast visibility
// Per-cell visibility test against a sorted list of shadow intervals.
// ----------------------------------------------------------------------------
// channel | valid   | stall   | payload
// request | i_valid | o_stall | viewer, octant, ring, column, occluder
// result  | o_valid | i_stall | cell_x, cell_y, in_radius, visible
// A request goes through accept, a compare in every slot at once,
// then the list update as the result is loaded.
// Reset and a request at ring 1, column 0 empty the list.
// A waiting result holds the update step; one further request can be
// accepted while it waits.
`default_nettype none
module octant_shadowcast_visibility import osv_pkg::*; #(
    parameter int RADIUS      = 16,
    parameter int MAX_SHADOWS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic        [7:0] i_viewer_x,
    input  wire logic        [7:0] i_viewer_y,
    input  wire logic        [2:0] i_octant,
    input  wire logic        [3:0] i_ring,
    input  wire logic        [3:0] i_column,
    input  wire logic              i_occluder,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic signed      [9:0] o_cell_x,
    output logic signed      [9:0] o_cell_y,
    output logic                   o_in_radius,
    output logic                   o_visible
);

    localparam int RadSq = RADIUS * RADIUS;
    localparam t_link EdgeLeft  = '{f: 1'b0, valid: 1'b0, shade: '0};
    localparam t_link EdgeRight = '{f: 1'b1, valid: 1'b0, shade: '0};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state;
    t_shade r_n;
    logic r_try;
    logic r_occ;
    logic r_inr;
    logic signed [9:0] r_cx;
    logic signed [9:0] r_cy;

    logic acc;
    logic upd_go;
    assign o_stall = (r_state != S_IDLE);
    assign acc     = i_valid && !o_stall;
    assign upd_go  = (r_state == S_UPD) && (!o_valid || !i_stall);

    logic [4:0] r5, c5;
    logic [7:0] rr, cc;
    logic [8:0] dist2;
    logic inr;
    logic signed [9:0] dx, dy;
    always_comb begin
        r5 = {1'b0, i_ring};
        c5 = {1'b0, i_column};
        rr = {4'b0, i_ring} * {4'b0, i_ring};
        cc = {4'b0, i_column} * {4'b0, i_column};
        dist2 = {1'b0, rr} + {1'b0, cc};
        inr = int'(dist2) < RadSq;
        case (i_octant)
            3'd0: begin dx = 10'(c5); dy = -10'(r5); end
            3'd1: begin dx = 10'(r5); dy = -10'(c5); end
            3'd2: begin dx = 10'(r5); dy = 10'(c5); end
            3'd3: begin dx = 10'(c5); dy = 10'(r5); end
            3'd4: begin dx = -10'(c5); dy = 10'(r5); end
            3'd5: begin dx = -10'(r5); dy = 10'(c5); end
            3'd6: begin dx = -10'(r5); dy = -10'(c5); end
            default: begin dx = -10'(c5); dy = -10'(r5); end
        endcase
    end

    t_link w_link [MAX_SHADOWS];
    logic [MAX_SHADOWS-1:0] w_cover;
    logic [MAX_SHADOWS-1:0] w_prev_hit;
    logic [MAX_SHADOWS-1:0] w_next_hit;
    logic any_cov;
    logic hp;
    logic hn;
    logic full;
    logic vis;
    t_op upd_op;
    t_bcast bc;

    assign any_cov = |w_cover;
    assign hp      = |w_prev_hit;
    assign hn      = |w_next_hit;
    assign full    = w_link[MAX_SHADOWS-1].valid;
    assign vis     = r_try && !any_cov;

    always_comb begin
        upd_op = OP_NONE;
        if (upd_go && vis && r_occ) begin
            if (hn && hp) upd_op = OP_JOIN;
            else if (hn) upd_op = OP_START;
            else if (hp) upd_op = OP_END;
            else if (!full) upd_op = OP_INSERT;
        end
    end

    assign bc = '{clear: acc && i_ring == 4'd1 && i_column == 4'd0,
                  check: r_state == S_CMP,
                  op: upd_op,
                  shade: r_n};

    for (genvar k = 0; k < MAX_SHADOWS; k++) begin : g_slot
        t_link left_link;
        t_link right_link;
        if (k == 0) begin : g_first
            assign left_link = EdgeLeft;
        end else begin : g_inner_l
            assign left_link = w_link[k-1];
        end
        if (k == MAX_SHADOWS - 1) begin : g_last
            assign right_link = EdgeRight;
        end else begin : g_inner_r
            assign right_link = w_link[k+1];
        end
        osv_cell u_slot (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_bc(bc),
            .i_left(left_link),
            .i_right(right_link),
            .o_link(w_link[k]),
            .o_cover(w_cover[k]),
            .o_prev_hit(w_prev_hit[k]),
            .o_next_hit(w_next_hit[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_valid     <= 1'b0;
            r_n         <= '0;
            r_try       <= 1'b0;
            r_occ       <= 1'b0;
            r_inr       <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            o_cell_x    <= '0;
            o_cell_y    <= '0;
            o_in_radius <= 1'b0;
            o_visible   <= 1'b0;
        end else begin
            o_valid <= upd_go || (o_valid && i_stall);
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_cx    <= 10'({2'b0, i_viewer_x}) + dx;
                        r_cy    <= 10'({2'b0, i_viewer_y}) + dy;
                        r_inr   <= inr;
                        r_try   <= inr && i_ring != 4'd0;
                        r_occ   <= i_occluder;
                        r_n     <= '{sn: c5, sd: r5 + 5'd1, en: c5 + 5'd1, ed: r5};
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (upd_go) begin
                        o_cell_x    <= r_cx;
                        o_cell_y    <= r_cy;
                        o_in_radius <= r_inr;
                        o_visible   <= vis;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |-> o_in_radius) else $error("visible outside radius");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |=> r_state == S_UPD) else $error("sequence broken");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_x) && $stable(o_cell_y)
        && $stable(o_in_radius) && $stable(o_visible)) else $error("held result changed");
`endif

endmodule
`default_nettype wire

### dv/octant_shadowcast_visibility_test.sv
// ----------------------------------------------------------------------------
// Octant shadowcast visibility testbench
// Streams octant scans and random cells into the block, predicts every result
// with a local shadow list, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module octant_shadowcast_visibility_test;

    localparam int RADIUS      = 16;
    localparam int MAX_SHADOWS = 16;
    localparam int IdleLimit   = 5000;

    typedef struct packed {
        logic [7:0] vx;
        logic [7:0] vy;
        logic [2:0] oct;
        logic [3:0] ring;
        logic [3:0] col;
        logic       occ;
    } t_cell;

    typedef struct packed {
        logic [9:0] cx;
        logic [9:0] cy;
        logic       inr;
        logic       vis;
    } t_view;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [7:0] i_viewer_x;
    logic [7:0] i_viewer_y;
    logic [2:0] i_octant;
    logic [3:0] i_ring;
    logic [3:0] i_column;
    logic i_occluder;
    logic o_valid;
    logic i_stall;
    logic signed [9:0] o_cell_x;
    logic signed [9:0] o_cell_y;
    logic o_in_radius;
    logic o_visible;

    octant_shadowcast_visibility #(.RADIUS(RADIUS), .MAX_SHADOWS(MAX_SHADOWS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_viewer_x(i_viewer_x), .i_viewer_y(i_viewer_y), .i_octant(i_octant),
        .i_ring(i_ring), .i_column(i_column), .i_occluder(i_occluder),
        .o_valid(o_valid), .i_stall(i_stall), .o_cell_x(o_cell_x), .o_cell_y(o_cell_y),
        .o_in_radius(o_in_radius), .o_visible(o_visible)
    );

    t_cell  pending_cells[$];
    t_view  expected_views[$];
    int     shade_sn[MAX_SHADOWS], shade_sd[MAX_SHADOWS];
    int     shade_en[MAX_SHADOWS], shade_ed[MAX_SHADOWS];
    int     shade_count;
    int     errors;
    int     idle_cycles;
    int     hold_cycles;
    bit     held_once;
    bit     calm;
    bit     stimulus_done;
    bit     pause_sender;

    function automatic bit less_eq(int a, int b, int c, int d);
        return a * d <= c * b;
    endfunction

    function automatic bit less(int a, int b, int c, int d);
        return a * d < c * b;
    endfunction

    function automatic void add_shadow(int sn, int sd, int en, int ed);
        int i;
        int k;
        bit prev_hit;
        bit next_hit;
        for (i = 0; i < shade_count; i++) begin
            if (less_eq(sn, sd, shade_sn[i], shade_sd[i])) break;
        end
        prev_hit = i > 0 && less(sn, sd, shade_en[i-1], shade_ed[i-1]);
        next_hit = i < shade_count && less(shade_sn[i], shade_sd[i], en, ed);
        if (next_hit) begin
            if (prev_hit) begin
                shade_en[i-1] = shade_en[i];
                shade_ed[i-1] = shade_ed[i];
                for (k = i; k + 1 < shade_count; k++) begin
                    shade_sn[k] = shade_sn[k+1]; shade_sd[k] = shade_sd[k+1];
                    shade_en[k] = shade_en[k+1]; shade_ed[k] = shade_ed[k+1];
                end
                shade_count--;
            end else begin
                shade_sn[i] = sn;
                shade_sd[i] = sd;
            end
        end else if (prev_hit) begin
            shade_en[i-1] = en;
            shade_ed[i-1] = ed;
        end else if (shade_count < MAX_SHADOWS) begin
            for (k = shade_count; k > i; k--) begin
                shade_sn[k] = shade_sn[k-1]; shade_sd[k] = shade_sd[k-1];
                shade_en[k] = shade_en[k-1]; shade_ed[k] = shade_ed[k-1];
            end
            shade_sn[i] = sn; shade_sd[i] = sd; shade_en[i] = en; shade_ed[i] = ed;
            shade_count++;
        end
    endfunction

    function automatic t_view predict_view(t_cell req);
        t_view v;
        int r;
        int c;
        int dx;
        int dy;
        bit hidden;
        r = req.ring;
        c = req.col;
        if (r == 1 && c == 0) shade_count = 0;
        case (req.oct)
            3'd0: begin dx = c;  dy = -r; end
            3'd1: begin dx = r;  dy = -c; end
            3'd2: begin dx = r;  dy = c;  end
            3'd3: begin dx = c;  dy = r;  end
            3'd4: begin dx = -c; dy = r;  end
            3'd5: begin dx = -r; dy = c;  end
            3'd6: begin dx = -r; dy = -c; end
            default: begin dx = -c; dy = -r; end
        endcase
        v.cx = 10'(int'(req.vx) + dx);
        v.cy = 10'(int'(req.vy) + dy);
        v.inr = (r * r + c * c) < RADIUS * RADIUS;
        v.vis = 1'b0;
        if (v.inr && r != 0) begin
            hidden = 1'b0;
            for (int k = 0; k < shade_count; k++) begin
                if (less_eq(shade_sn[k], shade_sd[k], c, r + 1) &&
                    less_eq(c + 1, r, shade_en[k], shade_ed[k])) hidden = 1'b1;
            end
            v.vis = !hidden;
            if (v.vis && req.occ) add_shadow(c, r + 1, c + 1, r);
        end
        return v;
    endfunction

    function automatic t_cell random_cell();
        t_cell req;
        req.vx = 8'($urandom);
        req.vy = 8'($urandom);
        req.oct = 3'($urandom);
        req.ring = 4'($urandom);
        req.col = 4'($urandom);
        req.occ = 1'($urandom);
        return req;
    endfunction

    task automatic queue_octant_scan(int occ_pct);
        t_cell req;
        int rings;
        req = random_cell();
        rings = $urandom_range(3, 15);
        for (int r = 1; r <= rings; r++) begin
            for (int c = 0; c <= r; c++) begin
                req.ring = 4'(r);
                req.col = 4'(c);
                req.occ = $urandom_range(0, 99) < occ_pct;
                pending_cells.push_back(req);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        t_cell req;
        int queued;
        i_rst_n = 1'b0;
        stimulus_done = 1'b0;
        pause_sender = 1'b0;
        calm = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        req = '{vx: 8'd0, vy: 8'd0, oct: 3'd0, ring: 4'd1, col: 4'd0, occ: 1'b1};
        for (int o = 0; o < 8; o++) begin
            req.oct = 3'(o);
            req.vx = (o % 2) ? 8'hFF : 8'h00;
            req.vy = (o < 4) ? 8'h00 : 8'hFF;
            pending_cells.push_back(req);
        end
        req = '{vx: 8'h80, vy: 8'h7F, oct: 3'd3, ring: 4'd0, col: 4'd0, occ: 1'b1};
        pending_cells.push_back(req);
        req.ring = 4'd2; req.col = 4'd9;
        pending_cells.push_back(req);
        req.ring = 4'd15; req.col = 4'd15;
        pending_cells.push_back(req);
        req.ring = 4'd15; req.col = 4'd0;
        pending_cells.push_back(req);
        req.ring = 4'd11; req.col = 4'd11;
        pending_cells.push_back(req);
        req.ring = 4'd0; req.col = 4'd15; req.occ = 1'b0;
        pending_cells.push_back(req);
        // Scattered occluders in one octant build up many separate shadows.
        req = '{vx: 8'h10, vy: 8'hF0, oct: 3'd5, ring: 4'd1, col: 4'd0, occ: 1'b0};
        pending_cells.push_back(req);
        req.ring = 4'd14;
        for (int c = 0; c <= 14; c += 2) begin
            req.col = 4'(c); req.occ = 1'b1;
            pending_cells.push_back(req);
        end
        req.ring = 4'd13; req.col = 4'd1;
        pending_cells.push_back(req);

        queued = pending_cells.size();
        while (queued < 1200) begin
            if ($urandom_range(0, 9) < 8) begin
                queue_octant_scan($urandom_range(5, 60));
            end else begin
                for (int k = 0; k < 20; k++) pending_cells.push_back(random_cell());
            end
            queued = pending_cells.size() + queued;
            while (pending_cells.size() > 0) @(posedge i_clk);
            if (queued > 400 && queued < 700 && !calm) begin
                calm = 1'b1;
                queue_octant_scan(30);
                queue_octant_scan(30);
                queued = pending_cells.size() + queued;
                while (pending_cells.size() > 0) @(posedge i_clk);
                calm = 1'b0;
            end
            if (queued > 700 && !pause_sender) begin
                pause_sender = 1'b1;
                while (expected_views.size() > 0 || i_valid) @(posedge i_clk);
            end
        end
        while (pending_cells.size() > 0 || i_valid) @(posedge i_clk);
        stimulus_done = 1'b1;
    end

    always @(posedge i_clk) begin
        t_cell req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_viewer_x <= '0; i_viewer_y <= '0; i_octant <= '0;
            i_ring <= '0; i_column <= '0; i_occluder <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                req = '{vx: i_viewer_x, vy: i_viewer_y, oct: i_octant,
                        ring: i_ring, col: i_column, occ: i_occluder};
                expected_views.push_back(predict_view(req));
            end
            if (pending_cells.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
                req = pending_cells.pop_front();
                i_valid <= 1'b1;
                i_viewer_x <= req.vx; i_viewer_y <= req.vy; i_octant <= req.oct;
                i_ring <= req.ring; i_column <= req.col; i_occluder <= req.occ;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_view v;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_cycles = 0;
            held_once = 1'b0;
            errors = 0;
            idle_cycles = 0;
        end else begin
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (o_valid && !i_stall) begin
                if (expected_views.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    v = expected_views.pop_front();
                    if (o_cell_x !== v.cx) begin
                        $error("cell_x expected %0d actual %0d", $signed(v.cx), o_cell_x);
                        errors++;
                    end
                    if (o_cell_y !== v.cy) begin
                        $error("cell_y expected %0d actual %0d", $signed(v.cy), o_cell_y);
                        errors++;
                    end
                    if (o_in_radius !== v.inr) begin
                        $error("in_radius expected %0d actual %0d", v.inr, o_in_radius);
                        errors++;
                    end
                    if (o_visible !== v.vis) begin
                        $error("visible expected %0d actual %0d", v.vis, o_visible);
                        errors++;
                    end
                end
            end
            if (hold_cycles == 0 && !held_once && !calm && pending_cells.size() >= 20) begin
                hold_cycles = 200;
                held_once = 1'b1;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && $urandom_range(0, 99) < 23;
            end
            if (idle_cycles >= IdleLimit) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (expected_views.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_views.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
